/* sv/cfe_pkg.sv */
// ----------------------------------------------------------------------------
// cfe_pkg: shared types and constants
// Fixed-point constants, CORDIC arctangent table and stage struct.
// ----------------------------------------------------------------------------
package cfe_pkg;

  localparam int unsigned CW = 22;   // CORDIC datapath width (signed)
  localparam int unsigned AW = 20;   // angle width, units of pi/2^17
  localparam int unsigned TAB_LEN = 24;

  // tile edge in pixels; a power of two so the normalization is a shift
  localparam int unsigned TILE_EDGE = 256;
  localparam int unsigned TILE_LOG  = 8;

  localparam logic signed [CW-1:0] ONE_Q16     = CW'(65536);
  localparam logic signed [AW-1:0] HALF_PI_ANG = AW'(65536);
  localparam logic signed [AW-1:0] PI_ANG      = AW'(131072);
  localparam logic [15:0]          INV_GAIN    = 16'd39797;

  localparam logic [2:0] FACE_FRONT = 3'd0;
  localparam logic [2:0] FACE_BACK  = 3'd1;
  localparam logic [2:0] FACE_LEFT  = 3'd2;
  localparam logic [2:0] FACE_RIGHT = 3'd3;
  localparam logic [2:0] FACE_UP    = 3'd4;
  localparam logic [2:0] FACE_DOWN  = 3'd5;

  localparam logic [0:0] CFG_HEIGHT = 1'd0;
  localparam logic [0:0] CFG_ZOOM   = 1'd1;

  function automatic logic [AW-1:0] atan_tab(input int unsigned i);
    logic [AW-1:0] v;
    case (i)
      0: v = AW'(32768);  1: v = AW'(19344); 2: v = AW'(10221); 3: v = AW'(5188);
      4: v = AW'(2604);   5: v = AW'(1303);  6: v = AW'(652);   7: v = AW'(326);
      8: v = AW'(163);    9: v = AW'(81);    10: v = AW'(41);   11: v = AW'(20);
      12: v = AW'(10);    13: v = AW'(5);    14: v = AW'(3);    15: v = AW'(1);
      16: v = AW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // one vectoring CORDIC lane
  typedef struct packed {
    logic                 zero;  // pass input was the zero vector
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] ang;
  } cord_t;

endpackage

/* sv/cfe_cordic.sv */
// ----------------------------------------------------------------------------
// cfe_cordic: pipelined vectoring CORDIC
// One register stage per iteration, stall-aware, carries a side payload.
// ----------------------------------------------------------------------------
module cfe_cordic import cfe_pkg::*; #(
  parameter int unsigned STEPS = 18,
  parameter int unsigned SW    = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] in_x,
  input  logic signed [CW-1:0] in_y,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic signed [CW-1:0] out_mag,
  output logic signed [AW-1:0] out_ang,
  output logic [SW-1:0]        out_side
);

  cord_t         st_r   [STEPS+1];
  logic [SW-1:0] side_r [STEPS+1];
  logic          vld_r  [STEPS+1];
  cord_t         pre;

  // quadrant pre-rotation for x < 0
  always_comb begin
    pre.zero = (in_x == '0) && (in_y == '0);
    pre.x    = in_x;
    pre.y    = in_y;
    pre.ang  = '0;
    if (in_x < 0) begin
      if (in_y >= 0) begin
        pre.x = in_y; pre.y = -in_x; pre.ang = HALF_PI_ANG;
      end else begin
        pre.x = -in_y; pre.y = in_x; pre.ang = -HALF_PI_ANG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else if (adv) vld_r[0] <= in_valid;
    if (adv) begin
      st_r[0]   <= pre;
      side_r[0] <= in_side;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_it
    cord_t nx;
    always_comb begin
      nx = st_r[i];
      if (st_r[i].y >= 0) begin
        nx.x   = st_r[i].x + (st_r[i].y >>> i);
        nx.y   = st_r[i].y - (st_r[i].x >>> i);
        nx.ang = st_r[i].ang + atan_tab(i);
      end else begin
        nx.x   = st_r[i].x - (st_r[i].y >>> i);
        nx.y   = st_r[i].y + (st_r[i].x >>> i);
        nx.ang = st_r[i].ang - atan_tab(i);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i+1] <= 1'b0;
      else if (adv) vld_r[i+1] <= vld_r[i];
      if (adv) begin
        st_r[i+1]   <= nx;
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign out_valid = vld_r[STEPS];
  assign out_mag   = st_r[STEPS].zero ? '0 : st_r[STEPS].x;
  assign out_ang   = st_r[STEPS].zero ? '0 : st_r[STEPS].ang;
  assign out_side  = side_r[STEPS];

endmodule

/* sv/cubemap_face_to_equirect_coord.sv */
// ----------------------------------------------------------------------------
// cubemap_face_to_equirect_coord: cube-face pixel to equirect source address
// Maps one cube-map pixel request to the source column, row and index.
// ----------------------------------------------------------------------------
// Throughput is one request per clock while the output is not stalled. The
// stages, in order: coordinate setup, vector build, first CORDIC pass,
// gain removal multiply, second CORDIC pass, the two H multiplies,
// the index multiply and the output register.
// The whole pipeline advances when the output register is empty or being
// taken, so in_stall is simply the output stall with a full output stage.
// Face codes 6 and 7 yield the zero vector. zoom_level above MAX_LEVEL acts
// as MAX_LEVEL; source_height saturates to [1, 2^HEIGHT_BITS].
module cubemap_face_to_equirect_coord import cfe_pkg::*; #(
  parameter int unsigned MAX_LEVEL    = 5,
  parameter int unsigned HEIGHT_BITS  = 13,
  parameter int unsigned CORDIC_STEPS = 18
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [13:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_face,
  input  logic [4:0]  in_tile_col,
  input  logic [4:0]  in_tile_row,
  input  logic [7:0]  in_pix_x,
  input  logic [7:0]  in_pix_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] out_src_col,
  output logic [12:0] out_src_row,
  output logic [26:0] out_src_index
);

  localparam int unsigned HW = HEIGHT_BITS + 1;

  logic [13:0] height_r;
  logic [2:0]  zoom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= 14'd512;
      zoom_r   <= 3'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEIGHT: height_r <= cfg_data;
        CFG_ZOOM:   zoom_r   <= cfg_data[2:0];
        default:    ;
      endcase
    end
  end

  // Effective level and height
  logic [3:0]    lvl;
  logic [HW-1:0] h_eff;
  always_comb begin
    lvl = (32'(zoom_r) > MAX_LEVEL) ? 4'(MAX_LEVEL) : {1'b0, zoom_r};
    if (height_r == '0) h_eff = HW'(1);
    else if (32'(height_r) > (32'd1 << HEIGHT_BITS)) h_eff = HW'(1) << HEIGHT_BITS;
    else h_eff = HW'(height_r);
  end

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // --- stage 1: normalized coordinates --------------------------------------
  // a = (2p<<16)/(TILE_EDGE<<z) - 1.0 ; TILE_EDGE is a power of two, so the
  // divide is a left shift by 17-TILE_LOG and a right shift by z.
  function automatic logic signed [CW-1:0] norm(input logic [4:0] tile,
                                                input logic [7:0] pix,
                                                input logic [3:0] z);
    logic [4:0]  tm;
    logic [47:0] p;
    logic [47:0] q;
    tm = 5'((6'd1 << z) - 6'd1);
    p  = 48'(tile & tm) * 48'(TILE_EDGE) + 48'(pix);
    q  = (p << (17 - TILE_LOG)) >> z;
    return CW'(q) - ONE_Q16;
  endfunction

  logic                 v1_r;
  logic [2:0]           face1_r;
  logic signed [CW-1:0] a1_r, b1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_valid;
    if (adv) begin
      face1_r <= in_face;
      a1_r    <= norm(in_tile_col, in_pix_x, lvl);
      b1_r    <= norm(in_tile_row, in_pix_y, lvl);
    end
  end

  // --- stage 2: direction vector ----------------------------------------------
  logic                 v2_r;
  logic signed [CW-1:0] vx_r, vy_r, vz_r;
  logic signed [CW-1:0] vx, vy, vz;
  always_comb begin
    vx = '0; vy = '0; vz = '0;
    case (face1_r)
      FACE_FRONT: begin vx = ONE_Q16;  vy = a1_r;     vz = -b1_r;    end
      FACE_BACK:  begin vx = -ONE_Q16; vy = -a1_r;    vz = -b1_r;    end
      FACE_LEFT:  begin vx = a1_r;     vy = -ONE_Q16; vz = -b1_r;    end
      FACE_RIGHT: begin vx = -a1_r;    vy = ONE_Q16;  vz = -b1_r;    end
      FACE_UP:    begin vx = b1_r;     vy = a1_r;     vz = ONE_Q16;  end
      FACE_DOWN:  begin vx = -b1_r;    vy = a1_r;     vz = -ONE_Q16; end
      default:    ;
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
    if (adv) begin
      vx_r <= vx; vy_r <= vy; vz_r <= vz;
    end
  end

  // --- first CORDIC pass: theta, |(x,y)| --------------------------------------
  logic                 c1_v;
  logic signed [CW-1:0] c1_mag, c1_z;
  logic signed [AW-1:0] c1_ang;
  cfe_cordic #(.STEPS(CORDIC_STEPS), .SW(CW)) u_cord_xy (
    .clk, .rst_n, .adv,
    .in_valid(v2_r), .in_x(vx_r), .in_y(vy_r), .in_side(vz_r),
    .out_valid(c1_v), .out_mag(c1_mag), .out_ang(c1_ang), .out_side(c1_z)
  );

  // --- gain removal ----------------------------------------------------------
  logic                 v3_r;
  logic signed [CW-1:0] r3_r, z3_r;
  logic signed [AW-1:0] th3_r;
  logic signed [CW+17:0] gprod;
  assign gprod = (CW+18)'(c1_mag) * $signed({2'b0, INV_GAIN});
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= c1_v;
    if (adv) begin
      r3_r  <= CW'(gprod >>> 16);
      z3_r  <= c1_z;
      th3_r <= c1_ang;
    end
  end

  // --- second CORDIC pass: phi -------------------------------------------------
  logic                 c2_v;
  logic signed [CW-1:0] c2_mag;
  logic signed [AW-1:0] c2_ang, c2_th;
  cfe_cordic #(.STEPS(CORDIC_STEPS), .SW(AW)) u_cord_rz (
    .clk, .rst_n, .adv,
    .in_valid(v3_r), .in_x(r3_r), .in_y(z3_r), .in_side(th3_r),
    .out_valid(c2_v), .out_mag(c2_mag), .out_ang(c2_ang), .out_side(c2_th)
  );

  // --- column / row scaling ---------------------------------------------------
  logic [17:0]          t_w;
  logic signed [AW+1:0] p_s;
  logic [17:0]          p_w;
  assign t_w = 18'(c2_th + PI_ANG);
  assign p_s = (AW+2)'(HALF_PI_ANG) - (AW+2)'(c2_ang);
  always_comb begin
    if (p_s < 0) p_w = '0;
    else if (p_s > (AW+2)'(PI_ANG)) p_w = 18'(PI_ANG);
    else p_w = 18'(p_s);
  end

  logic                  v4_r;
  logic [HW-1:0]         u4_r, vr4_r;
  logic [HW-1:0]         uu, vv;
  logic [HW+17:0]        hu, hv;
  assign hu = (HW+18)'(h_eff) * (HW+18)'(t_w);
  assign hv = (HW+18)'(h_eff) * (HW+18)'(p_w);
  // u < 2*(2H) so one conditional subtract; v <= H
  always_comb begin
    uu = HW'(hu >> 17);
    if ((HW+1)'(uu) >= ((HW+1)'(h_eff) << 1)) uu = HW'((HW+1)'(uu) - ((HW+1)'(h_eff) << 1));
    vv = HW'(hv >> 17);
    if (vv >= h_eff) vv = vv - h_eff;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= c2_v;
    if (adv) begin
      u4_r  <= uu;
      vr4_r <= vv;
    end
  end

  // --- index multiply ------------------------------------------------------------
  logic          v5_r;
  logic [26:0]   idx5_r;
  logic [HW-1:0] u5_r, vr5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (adv) v5_r <= v4_r;
    if (adv) begin
      idx5_r <= 27'(54'(vr4_r) * 54'({h_eff, 1'b0}) + 54'(u4_r));
      u5_r   <= u4_r;
      vr5_r  <= vr4_r;
    end
  end

  // --- output register -----------------------------------------------------------
  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= v5_r;
    if (adv) begin
      out_src_col   <= 14'(u5_r);
      out_src_row   <= 13'(vr5_r);
      out_src_index <= idx5_r;
    end
  end
  assign out_valid = out_valid_r;

  logic unused_ok;
  assign unused_ok = ^c2_mag;

`ifndef SYNTHESIS
  a_stall_only_when_out_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output free");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_src_index)))
    else $error("result changed while stalled");
  a_row_below_h: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (14'(out_src_row) < h_eff))
    else $error("row out of range");
`endif

endmodule
